@@ rtl/rmq_pkg.sv @@
`default_nettype none
package rmq_pkg;
    localparam int IN_W  = 16;
    localparam int OUT_W = 16;
    localparam int BR_W  = 3;
    localparam logic [BR_W-1:0] BR_W_CASE    = 3'd0;
    localparam logic [BR_W-1:0] BR_X_CASE    = 3'd1;
    localparam logic [BR_W-1:0] BR_Y_CASE    = 3'd2;
    localparam logic [BR_W-1:0] BR_Z_CASE    = 3'd3;
    localparam logic [BR_W-1:0] BR_UNCOVERED = 3'd4;
endpackage
`default_nettype wire

@@ rtl/rmq_core.sv @@
`default_nettype none
module rmq_core #(
    parameter int FRAC_BITS = 14
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire logic                        i_valid,
    input  wire logic [9*rmq_pkg::IN_W-1:0]  i_mat,
    output logic                             o_valid,
    output logic [4*rmq_pkg::OUT_W+rmq_pkg::BR_W-1:0] o_res
);
    localparam int SW     = ((FRAC_BITS > 16) ? FRAC_BITS : 16) + 3;
    localparam int RW     = SW + FRAC_BITS + 1;
    localparam int RB     = RW / 2 + 1;
    localparam int RP     = 2 * RB;
    localparam int DW     = 19;
    localparam int NW     = DW + FRAC_BITS;
    localparam int NN     = NW + 2;
    localparam int QS     = NW + 1;
    localparam int SQ_PER = 3;
    localparam int DV_PER = 3;
    localparam int N_SQ   = (RB + SQ_PER - 1) / SQ_PER;
    localparam int N_DV   = (DW + DV_PER - 1) / DV_PER;
    localparam int N_STG  = N_SQ + N_DV + 4;

    typedef logic signed [SW-1:0] t_s;
    typedef logic signed [DW-1:0] t_d;

    typedef struct packed {
        logic [RW+1:0] rem;
        logic [RB-1:0] root;
        logic [RP-1:0] rad;
    } t_sq;

    typedef struct packed {
        logic [NN-1:0] rem;
        logic [DW-1:0] lo;
        logic [DW-1:0] q;
    } t_dv;

    logic [N_STG-1:0] r_vld;
    assign o_valid = r_vld[N_STG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[N_STG-2:0], i_valid};
        end
    end

    logic signed [rmq_pkg::IN_W-1:0] m [9];
    always_comb begin
        for (int k = 0; k < 9; k++) begin
            m[k] = i_mat[k*rmq_pkg::IN_W +: rmq_pkg::IN_W];
        end
    end

    t_s xx, yy, zz, one_s;
    assign xx = t_s'(m[0]);
    assign yy = t_s'(m[4]);
    assign zz = t_s'(m[8]);
    assign one_s = t_s'(1) <<< FRAC_BITS;

    logic [rmq_pkg::BR_W-1:0] n_br;
    t_s n_s;
    t_d n_d [3];
    always_comb begin
        t_d xy, xz, yx, yz, zx, zy;
        xy = t_d'(m[1]); xz = t_d'(m[2]); yx = t_d'(m[3]);
        yz = t_d'(m[5]); zx = t_d'(m[6]); zy = t_d'(m[7]);
        n_br = rmq_pkg::BR_UNCOVERED;
        n_s  = '0;
        n_d[0] = zy - yz; n_d[1] = xz - zx; n_d[2] = yx - xy;
        if (yy > -zz && xx > -yy && xx > -zz) begin
            n_br = rmq_pkg::BR_W_CASE;
            n_s  = one_s + xx + yy + zz;
        end else if (yy < -zz && xx > yy && xx > zz) begin
            n_br = rmq_pkg::BR_X_CASE;
            n_s  = one_s + xx - yy - zz;
            n_d[0] = zy - yz; n_d[1] = xy + yx; n_d[2] = zx + xz;
        end else if (yy > zz && xx < yy && xx < -zz) begin
            n_br = rmq_pkg::BR_Y_CASE;
            n_s  = one_s - xx + yy - zz;
            n_d[0] = xz - zx; n_d[1] = xy + yx; n_d[2] = yz + zy;
        end else if (yy < zz && xx < -yy && xx < zz) begin
            n_br = rmq_pkg::BR_Z_CASE;
            n_s  = one_s - xx - yy + zz;
            n_d[0] = yx - xy; n_d[1] = zx + xz; n_d[2] = yz + zy;
        end
        if (n_s <= 0) begin
            n_br = rmq_pkg::BR_UNCOVERED;
        end
    end

    // stage 1: branch select
    logic [rmq_pkg::BR_W-1:0] r_br1;
    logic [RW-1:0] r_rad1;
    t_d r_d1 [3];
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_br1  <= n_br;
            r_rad1 <= RW'($unsigned(n_s)) << FRAC_BITS;
            r_d1   <= n_d;
        end
    end

    // root stages: SQ_PER root bits per stage, radicand taken two bits at a time from the top
    function automatic t_sq sq_step(input t_sq a);
        t_sq           o;
        logic [RW+1:0] trial;
        o.rem = {a.rem[RW-1:0], a.rad[RP-1 -: 2]};
        o.rad = a.rad << 2;
        trial = {(RW-RB)'(0), a.root, 2'b01};
        if (o.rem >= trial) begin
            o.rem  = o.rem - trial;
            o.root = {a.root[RB-2:0], 1'b1};
        end else begin
            o.root = {a.root[RB-2:0], 1'b0};
        end
        return o;
    endfunction

    t_sq                      sq_src [N_SQ];
    t_sq                      n_sq [N_SQ];
    t_sq                      r_sq [N_SQ];
    logic [rmq_pkg::BR_W-1:0] r_sq_br [N_SQ];
    t_d                       r_sq_d [N_SQ][3];

    always_comb begin
        sq_src[0].rem  = '0;
        sq_src[0].root = '0;
        sq_src[0].rad  = RP'(r_rad1);
        for (int j = 1; j < N_SQ; j++) begin
            sq_src[j] = r_sq[j-1];
        end
    end

    always_comb begin
        t_sq st;
        for (int j = 0; j < N_SQ; j++) begin
            st = sq_src[j];
            for (int t = 0; t < SQ_PER; t++) begin
                if (j * SQ_PER + t < RB) begin
                    st = sq_step(st);
                end
            end
            n_sq[j] = st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq_br[0] <= r_br1;
            r_sq_d[0]  <= r_d1;
            for (int j = 0; j < N_SQ; j++) begin
                r_sq[j] <= n_sq[j];
            end
            for (int j = 1; j < N_SQ; j++) begin
                r_sq_br[j] <= r_sq_br[j-1];
                r_sq_d[j]  <= r_sq_d[j-1];
            end
        end
    end

    // prep stage: magnitudes and rounded numerators
    logic [RB-1:0] den_sq;
    assign den_sq = r_sq[N_SQ-1].root;

    logic [NN-1:0] n_num [3];
    logic          n_neg [3];
    always_comb begin
        logic [DW-1:0] mg;
        for (int k = 0; k < 3; k++) begin
            n_neg[k] = r_sq_d[N_SQ-1][k][DW-1];
            mg       = n_neg[k] ? DW'(-r_sq_d[N_SQ-1][k]) : DW'(r_sq_d[N_SQ-1][k]);
            n_num[k] = (NN'(mg) << FRAC_BITS) + NN'(den_sq);
        end
    end

    logic [rmq_pkg::BR_W-1:0] r_pn_br;
    logic [RB-1:0]            r_pn_den;
    logic [NN-1:0]            r_pn_num [3];
    logic                     r_pn_neg [3];
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pn_br  <= (den_sq == '0) ? rmq_pkg::BR_UNCOVERED : r_sq_br[N_SQ-1];
            r_pn_den <= den_sq;
            r_pn_num <= n_num;
            r_pn_neg <= n_neg;
        end
    end

    // divide stages: DV_PER quotient bits per stage, the quotient register is DW bits wide
    function automatic t_dv dv_step(input t_dv a, input logic [NN-1:0] dv);
        t_dv o;
        o.rem = {a.rem[NN-2:0], a.lo[DW-1]};
        o.lo  = a.lo << 1;
        if (o.rem >= dv) begin
            o.rem = o.rem - dv;
            o.q   = {a.q[DW-2:0], 1'b1};
        end else begin
            o.q   = {a.q[DW-2:0], 1'b0};
        end
        return o;
    endfunction

    t_dv                      dv_src [N_DV][3];
    logic [RB-1:0]            dv_den_src [N_DV];
    t_dv                      n_dv [N_DV][3];
    t_dv                      r_dv [N_DV][3];
    logic [RB-1:0]            r_dv_den [N_DV];
    logic [rmq_pkg::BR_W-1:0] r_dv_br [N_DV];
    logic                     r_dv_neg [N_DV][3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            dv_src[0][k].rem = r_pn_num[k] >> DW;
            dv_src[0][k].lo  = DW'(r_pn_num[k]);
            dv_src[0][k].q   = '0;
        end
        dv_den_src[0] = r_pn_den;
        for (int j = 1; j < N_DV; j++) begin
            dv_src[j]     = r_dv[j-1];
            dv_den_src[j] = r_dv_den[j-1];
        end
    end

    always_comb begin
        t_dv           st;
        logic [NN-1:0] dv;
        for (int j = 0; j < N_DV; j++) begin
            dv = NN'(dv_den_src[j]) << 1;
            for (int k = 0; k < 3; k++) begin
                st = dv_src[j][k];
                for (int t = 0; t < DV_PER; t++) begin
                    if (j * DV_PER + t < DW) begin
                        st = dv_step(st, dv);
                    end
                end
                n_dv[j][k] = st;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dv_br[0]  <= r_pn_br;
            r_dv_neg[0] <= r_pn_neg;
            for (int j = 0; j < N_DV; j++) begin
                r_dv[j]     <= n_dv[j];
                r_dv_den[j] <= dv_den_src[j];
            end
            for (int j = 1; j < N_DV; j++) begin
                r_dv_br[j]  <= r_dv_br[j-1];
                r_dv_neg[j] <= r_dv_neg[j-1];
            end
        end
    end

    // sign and saturate
    function automatic logic [rmq_pkg::OUT_W-1:0] sat(input logic [QS-1:0] q,
                                                      input logic neg);
        logic [QS-1:0] lim;
        lim = neg ? QS'(32768) : QS'(32767);
        if (q >= lim) begin
            return neg ? 16'h8000 : 16'h7FFF;
        end
        return neg ? 16'(-q) : 16'(q);
    endfunction

    logic [RB-1:0]            den_q;
    logic [rmq_pkg::BR_W-1:0] br_q;
    assign den_q = r_dv_den[N_DV-1];
    assign br_q  = r_dv_br[N_DV-1];

    logic [rmq_pkg::OUT_W-1:0] n_off [3];
    logic [rmq_pkg::OUT_W-1:0] n_half;
    logic [RB:0] half_w;
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_off[k] = sat(QS'(r_dv[N_DV-1][k].q), r_dv_neg[N_DV-1][k]);
        end
        half_w = ({1'b0, den_q} + 1'b1) >> 1;
        n_half = (half_w > (RB+1)'(32767)) ? 16'h7FFF : 16'(half_w);
    end

    logic [rmq_pkg::OUT_W-1:0] r_q4 [4];
    logic [rmq_pkg::BR_W-1:0]  r_br4;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_br4 <= br_q;
            case (br_q)
                rmq_pkg::BR_W_CASE: r_q4 <= '{n_half, n_off[0], n_off[1], n_off[2]};
                rmq_pkg::BR_X_CASE: r_q4 <= '{n_off[0], n_half, n_off[1], n_off[2]};
                rmq_pkg::BR_Y_CASE: r_q4 <= '{n_off[0], n_off[1], n_half, n_off[2]};
                rmq_pkg::BR_Z_CASE: r_q4 <= '{n_off[0], n_off[1], n_off[2], n_half};
                default:            r_q4 <= '{16'h0, 16'h0, 16'h0, 16'h0};
            endcase
        end
    end

    logic [rmq_pkg::OUT_W-1:0] r_q5 [4];
    logic [rmq_pkg::BR_W-1:0]  r_br5;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q5  <= r_q4;
            r_br5 <= r_br4;
        end
    end

    assign o_res = {r_br5, r_q5[3], r_q5[2], r_q5[1], r_q5[0]};
endmodule
`default_nettype wire

@@ rtl/rotation_matrix_to_quaternion_top.sv @@
// Pipeline stages from input beat to output beat (FRAC_BITS = 14:
// branch stage, six root stages, prep stage, seven divide stages, two output stages).
// Throughput: one beat per cycle when not stalled; the whole pipeline advances together.
// A stalled output register holds the pipeline and the input waits.
// Reset (i_rst_n low, synchronous) clears all valid bits; data registers keep content.
`default_nettype none
module rotation_matrix_to_quaternion_top #(
    parameter int FRAC_BITS = 14
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // r_xx, r_xy, r_xz, r_yx, r_yy, r_yz, r_zx, r_zy, r_zz
    input  wire logic [143:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // quat_w, quat_x, quat_y, quat_z, branch_used, 5 zero bits
    output logic [71:0]       m_axis_tdata
);
    logic        en;
    logic        vld;
    logic [66:0] res;

    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = vld;
    assign m_axis_tdata  = {5'b0, res};

    rmq_core #(.FRAC_BITS(FRAC_BITS)) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s_axis_tvalid),
        .i_mat   (s_axis_tdata),
        .o_valid (vld),
        .o_res   (res)
    );
endmodule
`default_nettype wire
